>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers; they compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define CAC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define CAC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define CAC_ASSERT(lbl, clk, rst_n, prop, msg)
`define CAC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> hw/rtl/cac_pkg.sv
// ----------------------------------------------------------------------------
// cac_pkg
// Types and fixed constants of the call arc counter.
// ----------------------------------------------------------------------------
package cac_pkg;

    // Fixed field widths
    localparam int TEXT_SIZE_W = 14;
    localparam int LIMIT_W     = 13;
    localparam int INDEX_W     = 12;
    localparam int STATUS_W    = 3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OFF   = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NEW   = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_HEAD  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_MOVED = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_OVF   = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_ENABLE    = 2'd0;
    localparam logic [1:0] CFG_TEXT_BASE = 2'd1;
    localparam logic [1:0] CFG_TEXT_SIZE = 2'd2;
    localparam logic [1:0] CFG_ARC_LIMIT = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_BKT,
        S_HEAD_RD,
        S_CMP_FIRST,
        S_CMP_NEXT,
        S_MOVE,
        S_ALLOC
    } t_state;

endpackage

>>> hw/rtl/call_arc_counter.sv
// ----------------------------------------------------------------------------
// call_arc_counter
// Call-graph arc recorder: hashed buckets of move-to-front arc chains.
// ----------------------------------------------------------------------------
// Usage:
//   Present one call on i_caller_addr / i_callee_addr with start high; the
//   item is taken at a rising edge where start is high and busy is low.
//   busy stays high while the item is worked on. The single result shows
//   on o_status / o_arc_index / o_arc_count for exactly one cycle, marked by
//   o_valid; the receiver cannot stall, so it must take it in that cycle.
//   Steps: S_CHECK ends a disabled or out-of-range call; the rest pass
//   S_DIV, and S_BKT ends one whose bucket falls past the table. Then
//   S_HEAD_RD: a miss on an empty bucket ends in S_ALLOC, a head hit in
//   S_CMP_FIRST; others walk the chain and end in S_MOVE or S_ALLOC.
//   The chain walk through the single read port of the arc memories sets
//   the rate: one link per cycle.
//   Configuration: i_cfg_we / i_cfg_idx / i_cfg_wdata write one register
//   per cycle; the user must write only while idle (not enforced).
//   Reset: control registers go to their defaults, then the bucket table
//   is swept to empty, all BUCKETS entries (4096 by default), one entry a
//   cycle, with busy high. Configuration writes are taken during the sweep.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module call_arc_counter
    import cac_pkg::*;
#(
    parameter int BUCKETS       = 4096,
    parameter int ARC_ENTRIES   = 4096,
    parameter int HASH_FRACTION = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // call items
    input  logic                start,
    output logic                busy,
    input  logic [31:0]         i_caller_addr,
    input  logic [31:0]         i_callee_addr,
    // results
    output logic                o_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [INDEX_W-1:0]  o_arc_index,
    output logic [31:0]         o_arc_count,
    // configuration writes
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_wdata
);

    // Index widths follow the table sizes
    localparam int IW = $clog2(ARC_ENTRIES);
    localparam int BW = $clog2(BUCKETS);
    localparam int SW = IW + 1;
    localparam int LW = (IW + 1 > LIMIT_W) ? IW + 1 : LIMIT_W;

    // Bucket = offset / (2 * HASH_FRACTION) by reciprocal multiply; the
    // offset is at most 14 bits, so six extra shift bits keep it exact.
    localparam int DIV   = 2 * HASH_FRACTION;
    localparam int SH    = TEXT_SIZE_W + 6;
    localparam int MUL_W = SH + 1;
    localparam int PW    = TEXT_SIZE_W + MUL_W;
    localparam logic [MUL_W-1:0] MUL = MUL_W'(((2 ** SH) + DIV - 1) / DIV);

    localparam logic [BW-1:0] CLR_LAST = BW'(BUCKETS - 1);
    localparam logic [LW-1:0] AE_LIM   = LW'(ARC_ENTRIES);
    localparam logic [SW-1:0] STEP_MAX = SW'(ARC_ENTRIES);

    // Sequencer and configuration
    t_state r_state, n_state;
    logic                   r_enable;
    logic [31:0]            r_text_base;
    logic [TEXT_SIZE_W-1:0] r_text_size;
    logic [LIMIT_W-1:0]     r_arc_limit;

    // Per-item working registers
    logic [31:0]            r_offset,    n_offset;
    logic [31:0]            r_callee,    n_callee;
    logic [PW-1:0]          r_prod,      n_prod;
    logic [BW-1:0]          r_bucket,    n_bucket;
    logic [IW-1:0]          r_head,      n_head;
    logic [IW-1:0]          r_cur,       n_cur;
    logic [IW-1:0]          r_prev,      n_prev;
    logic [SW-1:0]          r_steps,     n_steps;
    logic [31:0]            r_count,     n_count;

    // Allocator, clear sweep, result
    logic [IW-1:0]          r_next_free, n_next_free;
    logic                   r_overflowed, n_overflowed;
    logic [BW-1:0]          r_clr,       n_clr;
    logic                   r_valid,     n_valid;
    logic [STATUS_W-1:0]    r_status,    n_status;
    logic [INDEX_W-1:0]     r_index,     n_index;
    logic [31:0]            r_out_count, n_out_count;

    // Memories and their registered read data
    logic [IW-1:0] m_head   [0:BUCKETS-1];
    logic [31:0]   m_callee [0:ARC_ENTRIES-1];
    logic [31:0]   m_hits   [0:ARC_ENTRIES-1];
    logic [IW-1:0] m_next   [0:ARC_ENTRIES-1];
    logic [IW-1:0] r_bh_q;
    logic [31:0]   r_callee_q;
    logic [31:0]   r_hits_q;
    logic [IW-1:0] r_next_q;

    // Memory controls
    logic          bh_re, bh_we;
    logic [BW-1:0] bh_raddr, bh_waddr;
    logic [IW-1:0] bh_wdata;
    logic          arc_re;
    logic [IW-1:0] arc_raddr;
    logic          callee_we, hits_we, next_we;
    logic [IW-1:0] arc_waddr, next_waddr, next_wdata;
    logic [31:0]   hits_wdata;

    // Shared compare / increment datapath
    logic [TEXT_SIZE_W-1:0] q_bucket;
    logic                   bucket_ok;
    logic                   head_ok;
    logic                   match;
    logic                   follow;
    logic [31:0]            hits_inc;
    logic [LW-1:0]          alloc_idx;
    logic [LW-1:0]          limit_ext;
    logic [LW-1:0]          eff_limit;

    assign q_bucket  = r_prod[SH +: TEXT_SIZE_W];
    assign bucket_ok = (32'(q_bucket) < 32'(BUCKETS));
    assign head_ok   = (r_bh_q != '0) && (32'(r_bh_q) < 32'(ARC_ENTRIES));
    assign match     = (r_callee_q == r_callee);
    assign follow    = (r_next_q != '0) && (32'(r_next_q) < 32'(ARC_ENTRIES))
                       && (r_steps < STEP_MAX);
    assign hits_inc  = r_hits_q + 32'd1;
    assign alloc_idx = LW'(r_next_free) + LW'(1);
    assign limit_ext = LW'(r_arc_limit);
    assign eff_limit = (limit_ext > AE_LIM) ? AE_LIM : limit_ext;

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_arc_index = r_index;
    assign o_arc_count = r_out_count;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == CLR_LAST) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!r_enable || r_overflowed) n_state = S_IDLE;
                else if (r_offset > 32'(r_text_size)) n_state = S_IDLE;
                else n_state = S_DIV;
            end
            S_DIV: begin
                n_state = S_BKT;
            end
            S_BKT: begin
                n_state = bucket_ok ? S_HEAD_RD : S_IDLE;
            end
            S_HEAD_RD: begin
                n_state = head_ok ? S_CMP_FIRST : S_ALLOC;
            end
            S_CMP_FIRST: begin
                if (match) n_state = S_IDLE;
                else if (follow) n_state = S_CMP_NEXT;
                else n_state = S_ALLOC;
            end
            S_CMP_NEXT: begin
                if (match) n_state = S_MOVE;
                else if (follow) n_state = S_CMP_NEXT;
                else n_state = S_ALLOC;
            end
            S_MOVE: begin
                n_state = S_IDLE;
            end
            S_ALLOC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath control and memory ports
    // ------------------------------------------------------------------
    always_comb begin
        n_offset     = r_offset;
        n_callee     = r_callee;
        n_prod       = r_prod;
        n_bucket     = r_bucket;
        n_head       = r_head;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_steps      = r_steps;
        n_count      = r_count;
        n_next_free  = r_next_free;
        n_overflowed = r_overflowed;
        n_clr        = r_clr;
        n_valid      = 1'b0;
        n_status     = r_status;
        n_index      = r_index;
        n_out_count  = r_out_count;

        bh_re      = 1'b0;
        bh_raddr   = r_bucket;
        bh_we      = 1'b0;
        bh_waddr   = r_bucket;
        bh_wdata   = '0;
        arc_re     = 1'b0;
        arc_raddr  = r_next_q;
        callee_we  = 1'b0;
        hits_we    = 1'b0;
        arc_waddr  = r_cur;
        hits_wdata = hits_inc;
        next_we    = 1'b0;
        next_waddr = r_cur;
        next_wdata = r_head;

        case (r_state)
            S_CLEAR: begin
                // sweep the bucket table to empty
                bh_we    = 1'b1;
                bh_waddr = r_clr;
                n_clr    = r_clr + BW'(1);
            end
            S_IDLE: begin
                if (start) begin
                    n_offset = i_caller_addr - r_text_base;
                    n_callee = i_callee_addr;
                end
            end
            S_CHECK: begin
                if (!r_enable || r_overflowed) begin
                    n_valid     = 1'b1;
                    n_status    = STAT_OFF;
                    n_index     = '0;
                    n_out_count = '0;
                end else if (r_offset > 32'(r_text_size)) begin
                    n_valid     = 1'b1;
                    n_status    = STAT_RANGE;
                    n_index     = '0;
                    n_out_count = '0;
                end
            end
            S_DIV: begin
                n_prod = PW'(r_offset[TEXT_SIZE_W-1:0]) * PW'(MUL);
            end
            S_BKT: begin
                if (bucket_ok) begin
                    bh_re    = 1'b1;
                    bh_raddr = BW'(q_bucket);
                    n_bucket = BW'(q_bucket);
                end else begin
                    n_valid     = 1'b1;
                    n_status    = STAT_RANGE;
                    n_index     = '0;
                    n_out_count = '0;
                end
            end
            S_HEAD_RD: begin
                n_head  = r_bh_q;
                n_cur   = r_bh_q;
                n_steps = '0;
                if (head_ok) begin
                    arc_re    = 1'b1;
                    arc_raddr = r_bh_q;
                end
            end
            S_CMP_FIRST: begin
                if (match) begin
                    hits_we     = 1'b1;
                    n_valid     = 1'b1;
                    n_status    = STAT_HEAD;
                    n_index     = INDEX_W'(r_cur);
                    n_out_count = hits_inc;
                end else if (follow) begin
                    n_prev    = r_cur;
                    n_cur     = r_next_q;
                    n_steps   = r_steps + SW'(1);
                    arc_re    = 1'b1;
                end
            end
            S_CMP_NEXT: begin
                if (match) begin
                    // bump the count, unlink from predecessor
                    hits_we    = 1'b1;
                    n_count    = hits_inc;
                    next_we    = 1'b1;
                    next_waddr = r_prev;
                    next_wdata = r_next_q;
                end else if (follow) begin
                    n_prev    = r_cur;
                    n_cur     = r_next_q;
                    n_steps   = r_steps + SW'(1);
                    arc_re    = 1'b1;
                end
            end
            S_MOVE: begin
                // link the hit entry in front of the old head
                next_we     = 1'b1;
                bh_we       = 1'b1;
                bh_wdata    = r_cur;
                n_valid     = 1'b1;
                n_status    = STAT_MOVED;
                n_index     = INDEX_W'(r_cur);
                n_out_count = r_count;
            end
            S_ALLOC: begin
                n_valid = 1'b1;
                if (alloc_idx >= eff_limit) begin
                    n_overflowed = 1'b1;
                    n_status     = STAT_OVF;
                    n_index      = '0;
                    n_out_count  = '0;
                end else begin
                    n_next_free = IW'(alloc_idx);
                    callee_we   = 1'b1;
                    hits_we     = 1'b1;
                    arc_waddr   = IW'(alloc_idx);
                    hits_wdata  = 32'd1;
                    next_we     = 1'b1;
                    next_waddr  = IW'(alloc_idx);
                    bh_we       = 1'b1;
                    bh_wdata    = IW'(alloc_idx);
                    n_status    = STAT_NEW;
                    n_index     = INDEX_W'(alloc_idx);
                    n_out_count = 32'd1;
                end
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_enable     <= 1'b0;
            r_text_base  <= '0;
            r_text_size  <= TEXT_SIZE_W'(16383);
            r_arc_limit  <= LIMIT_W'(4096);
            r_next_free  <= '0;
            r_overflowed <= 1'b0;
            r_clr        <= '0;
            r_valid      <= 1'b0;
            r_steps      <= '0;
        end else begin
            r_state      <= n_state;
            r_next_free  <= n_next_free;
            r_overflowed <= n_overflowed;
            r_clr        <= n_clr;
            r_valid      <= n_valid;
            r_steps      <= n_steps;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ENABLE:    r_enable    <= i_cfg_wdata[0];
                    CFG_TEXT_BASE: r_text_base <= i_cfg_wdata;
                    CFG_TEXT_SIZE: r_text_size <= i_cfg_wdata[TEXT_SIZE_W-1:0];
                    CFG_ARC_LIMIT: r_arc_limit <= i_cfg_wdata[LIMIT_W-1:0];
                    default:       r_enable    <= r_enable;
                endcase
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_offset    <= n_offset;
        r_callee    <= n_callee;
        r_prod      <= n_prod;
        r_bucket    <= n_bucket;
        r_head      <= n_head;
        r_cur       <= n_cur;
        r_prev      <= n_prev;
        r_count     <= n_count;
        r_status    <= n_status;
        r_index     <= n_index;
        r_out_count <= n_out_count;
    end

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (bh_we) m_head[bh_waddr] <= bh_wdata;
        if (bh_re) r_bh_q <= m_head[bh_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (callee_we) m_callee[arc_waddr] <= r_callee;
        if (arc_re) r_callee_q <= m_callee[arc_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (hits_we) m_hits[arc_waddr] <= hits_wdata;
        if (arc_re) r_hits_q <= m_hits[arc_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (next_we) m_next[next_waddr] <= next_wdata;
        if (arc_re) r_next_q <= m_next[arc_raddr];
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `CAC_ASSERT(a_busy_after_take, i_clk, i_rst_n, start && !busy |=> busy, "item taken but not busy")
    `CAC_ASSERT(a_single_strobe, i_clk, i_rst_n, o_valid |=> !o_valid, "result strobe longer than one cycle")
    `CAC_ASSERT(a_valid_when_idle, i_clk, i_rst_n, o_valid |-> !busy, "result shown while still busy")
    `CAC_ASSERT(a_new_count_one, i_clk, i_rst_n, o_valid && o_status == STAT_NEW |-> o_arc_count == 32'd1, "new arc count not one")
    `CAC_ASSERT(a_alloc_bound, i_clk, i_rst_n, 32'(r_next_free) < 32'(ARC_ENTRIES), "allocator beyond table")

endmodule
